@@ rtl/core/scta_pkg.sv @@
// ----------------------------------------------------------------------------
// scta_pkg
// Types, request format and key tables shared by the scan code translator.
// ----------------------------------------------------------------------------
`default_nettype none

package scta_pkg;

  localparam logic [7:0] PrefixCode = 8'hE0;
  localparam logic [6:0] ShiftLCode = 7'h2A;
  localparam logic [6:0] ShiftRCode = 7'h36;
  localparam logic [6:0] CtrlCode   = 7'h1D;
  localparam logic [6:0] AltCode    = 7'h38;
  localparam logic [6:0] CapsCode   = 7'h3A;
  localparam logic [6:0] NumCode    = 7'h45;
  localparam logic [6:0] ScrollCode = 7'h46;
  localparam logic [5:0] CapsLo     = 6'h10;
  localparam logic [5:0] CapsHi     = 6'h32;
  localparam logic [6:0] LetterLoA  = 7'h61;
  localparam logic [6:0] LetterHiA  = 7'h7A;
  localparam logic [6:0] LetterLoU  = 7'h41;
  localparam logic [6:0] LetterHiU  = 7'h5A;

  typedef enum logic [2:0] {
    KindNone   = 3'd0,
    KindShift  = 3'd1,
    KindCtrl   = 3'd2,
    KindAlt    = 3'd3,
    KindCaps   = 3'd4,
    KindNum    = 3'd5,
    KindScroll = 3'd6,
    KindKey    = 3'd7
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic       make;
    logic [5:0] code;
  } req_t;

  function automatic logic [6:0] plain_map(input logic [5:0] code);
    logic [6:0] ch;
    unique case (code)
      6'h01: ch = 7'h1B;  6'h02: ch = 7'h31;  6'h03: ch = 7'h32;  6'h04: ch = 7'h33;
      6'h05: ch = 7'h34;  6'h06: ch = 7'h35;  6'h07: ch = 7'h36;  6'h08: ch = 7'h37;
      6'h09: ch = 7'h38;  6'h0A: ch = 7'h39;  6'h0B: ch = 7'h30;  6'h0C: ch = 7'h2D;
      6'h0D: ch = 7'h3D;  6'h0E: ch = 7'h08;  6'h0F: ch = 7'h09;  6'h10: ch = 7'h71;
      6'h11: ch = 7'h77;  6'h12: ch = 7'h65;  6'h13: ch = 7'h72;  6'h14: ch = 7'h74;
      6'h15: ch = 7'h79;  6'h16: ch = 7'h75;  6'h17: ch = 7'h69;  6'h18: ch = 7'h6F;
      6'h19: ch = 7'h70;  6'h1A: ch = 7'h5B;  6'h1B: ch = 7'h5D;  6'h1C: ch = 7'h0A;
      6'h1E: ch = 7'h61;  6'h1F: ch = 7'h73;  6'h20: ch = 7'h64;  6'h21: ch = 7'h66;
      6'h22: ch = 7'h67;  6'h23: ch = 7'h68;  6'h24: ch = 7'h6A;  6'h25: ch = 7'h6B;
      6'h26: ch = 7'h6C;  6'h27: ch = 7'h3B;  6'h28: ch = 7'h27;  6'h29: ch = 7'h60;
      6'h2B: ch = 7'h5C;  6'h2C: ch = 7'h7A;  6'h2D: ch = 7'h78;  6'h2E: ch = 7'h63;
      6'h2F: ch = 7'h76;  6'h30: ch = 7'h62;  6'h31: ch = 7'h6E;  6'h32: ch = 7'h6D;
      6'h33: ch = 7'h2C;  6'h34: ch = 7'h2E;  6'h35: ch = 7'h2F;  6'h37: ch = 7'h2A;
      6'h39: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [6:0] shifted_map(input logic [5:0] code);
    logic [6:0] ch;
    unique case (code)
      6'h01: ch = 7'h1B;  6'h02: ch = 7'h21;  6'h03: ch = 7'h40;  6'h04: ch = 7'h23;
      6'h05: ch = 7'h24;  6'h06: ch = 7'h25;  6'h07: ch = 7'h5E;  6'h08: ch = 7'h26;
      6'h09: ch = 7'h2A;  6'h0A: ch = 7'h28;  6'h0B: ch = 7'h29;  6'h0C: ch = 7'h5F;
      6'h0D: ch = 7'h2B;  6'h0E: ch = 7'h08;  6'h0F: ch = 7'h09;  6'h10: ch = 7'h51;
      6'h11: ch = 7'h57;  6'h12: ch = 7'h45;  6'h13: ch = 7'h52;  6'h14: ch = 7'h54;
      6'h15: ch = 7'h59;  6'h16: ch = 7'h55;  6'h17: ch = 7'h49;  6'h18: ch = 7'h4F;
      6'h19: ch = 7'h50;  6'h1A: ch = 7'h7B;  6'h1B: ch = 7'h7D;  6'h1C: ch = 7'h0A;
      6'h1E: ch = 7'h41;  6'h1F: ch = 7'h53;  6'h20: ch = 7'h44;  6'h21: ch = 7'h46;
      6'h22: ch = 7'h47;  6'h23: ch = 7'h48;  6'h24: ch = 7'h4A;  6'h25: ch = 7'h4B;
      6'h26: ch = 7'h4C;  6'h27: ch = 7'h3A;  6'h28: ch = 7'h22;  6'h29: ch = 7'h7E;
      6'h2B: ch = 7'h7C;  6'h2C: ch = 7'h5A;  6'h2D: ch = 7'h58;  6'h2E: ch = 7'h43;
      6'h2F: ch = 7'h56;  6'h30: ch = 7'h42;  6'h31: ch = 7'h4E;  6'h32: ch = 7'h4D;
      6'h33: ch = 7'h3C;  6'h34: ch = 7'h3E;  6'h35: ch = 7'h3F;  6'h37: ch = 7'h2A;
      6'h39: ch = 7'h20;
      default: ch = 7'h00;
    endcase
    return ch;
  endfunction

endpackage

`default_nettype wire

@@ rtl/core/scta_front.sv @@
// ----------------------------------------------------------------------------
// scta_front
// Classifies each raw scan code into a request for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module scta_front (
  input  wire logic [7:0]  scan_code_i,
  output scta_pkg::req_t   req_o
);

  logic       make;
  logic [6:0] code;

  assign make = ~scan_code_i[7];
  assign code = scan_code_i[6:0];

  always_comb begin
    req_o.make = make;
    req_o.code = code[5:0];
    req_o.kind = scta_pkg::KindNone;
    if (scan_code_i != scta_pkg::PrefixCode) begin
      if (code == scta_pkg::ShiftLCode || code == scta_pkg::ShiftRCode) begin
        req_o.kind = scta_pkg::KindShift;
      end else if (code == scta_pkg::CtrlCode) begin
        req_o.kind = scta_pkg::KindCtrl;
      end else if (code == scta_pkg::AltCode) begin
        req_o.kind = scta_pkg::KindAlt;
      end else if (code == scta_pkg::CapsCode) begin
        req_o.kind = make ? scta_pkg::KindCaps : scta_pkg::KindNone;
      end else if (code == scta_pkg::NumCode) begin
        req_o.kind = make ? scta_pkg::KindNum : scta_pkg::KindNone;
      end else if (code == scta_pkg::ScrollCode) begin
        req_o.kind = make ? scta_pkg::KindScroll : scta_pkg::KindNone;
      end else if (make && !code[6]) begin
        req_o.kind = scta_pkg::KindKey;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/scta_fifo.sv @@
// ----------------------------------------------------------------------------
// scta_fifo
// Small flop-based request queue between front and back end.
// ----------------------------------------------------------------------------
`default_nettype none

module scta_fifo #(
  parameter int Depth = 2
) (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           push_i,
  input  wire scta_pkg::req_t push_req_i,
  output logic                full_o,
  input  wire logic           pop_i,
  output scta_pkg::req_t      pop_req_o,
  output logic                empty_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  scta_pkg::req_t mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            do_push;
  logic            do_pop;

  assign full_o    = (count_q == CntW'(Depth));
  assign empty_o   = (count_q == '0);
  assign do_push   = push_i & ~full_o;
  assign do_pop    = pop_i & ~empty_o;
  assign pop_req_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_req_i;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/scta_back.sv @@
// ----------------------------------------------------------------------------
// scta_back
// Keeps modifier and lock state, translates keys and holds the result.
// ----------------------------------------------------------------------------
`default_nettype none

module scta_back (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           req_valid_i,
  input  wire scta_pkg::req_t req_i,
  output logic                req_pop_o,
  output logic                out_valid_o,
  input  wire logic           out_stall_i,
  output logic                char_valid_o,
  output logic [6:0]          char_code_o,
  output logic                led_valid_o,
  output logic [2:0]          led_bits_o
);

  logic       shift_q, shift_d;
  logic       ctrl_q, ctrl_d;
  logic       alt_q, alt_d;
  logic       caps_q, caps_d;
  logic       num_q, num_d;
  logic       scroll_q, scroll_d;
  logic       out_valid_q;
  logic       char_valid_q, char_valid_d;
  logic [6:0] char_code_q, char_code_d;
  logic       led_valid_q, led_valid_d;
  logic [2:0] led_bits_q;
  logic       use_shifted;
  logic [6:0] ch;
  logic       is_letter;

  assign req_pop_o = req_valid_i & (~out_valid_q | ~out_stall_i);

  assign use_shifted = shift_q | (caps_q & (req_i.code >= scta_pkg::CapsLo)
                                        & (req_i.code <= scta_pkg::CapsHi));
  assign ch = use_shifted ? scta_pkg::shifted_map(req_i.code)
                          : scta_pkg::plain_map(req_i.code);
  assign is_letter = (ch >= scta_pkg::LetterLoA && ch <= scta_pkg::LetterHiA) ||
                     (ch >= scta_pkg::LetterLoU && ch <= scta_pkg::LetterHiU);

  always_comb begin
    shift_d      = shift_q;
    ctrl_d       = ctrl_q;
    alt_d        = alt_q;
    caps_d       = caps_q;
    num_d        = num_q;
    scroll_d     = scroll_q;
    char_valid_d = 1'b0;
    char_code_d  = '0;
    led_valid_d  = 1'b0;
    unique case (req_i.kind)
      scta_pkg::KindShift:  shift_d = req_i.make;
      scta_pkg::KindCtrl:   ctrl_d  = req_i.make;
      scta_pkg::KindAlt:    alt_d   = req_i.make;
      scta_pkg::KindCaps: begin
        caps_d      = ~caps_q;
        led_valid_d = 1'b1;
      end
      scta_pkg::KindNum: begin
        num_d       = ~num_q;
        led_valid_d = 1'b1;
      end
      scta_pkg::KindScroll: begin
        scroll_d    = ~scroll_q;
        led_valid_d = 1'b1;
      end
      scta_pkg::KindKey: begin
        char_valid_d = (ch != '0);
        char_code_d  = (ctrl_q && is_letter) ? {2'b00, ch[4:0]} : ch;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shift_q     <= 1'b0;
      ctrl_q      <= 1'b0;
      alt_q       <= 1'b0;
      caps_q      <= 1'b0;
      num_q       <= 1'b0;
      scroll_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (req_pop_o) begin
        shift_q  <= shift_d;
        ctrl_q   <= ctrl_d;
        alt_q    <= alt_d;
        caps_q   <= caps_d;
        num_q    <= num_d;
        scroll_q <= scroll_d;
      end
      if (req_pop_o) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_pop_o) begin
      char_valid_q <= char_valid_d;
      char_code_q  <= char_code_d;
      led_valid_q  <= led_valid_d;
      led_bits_q   <= {caps_d, num_d, scroll_d};
    end
  end

  assign out_valid_o  = out_valid_q;
  assign char_valid_o = char_valid_q;
  assign char_code_o  = char_code_q;
  assign led_valid_o  = led_valid_q;
  assign led_bits_o   = led_bits_q;

endmodule

`default_nettype wire

@@ rtl/core/scan_code_to_ascii_translator_core.sv @@
// ----------------------------------------------------------------------------
// scan_code_to_ascii_translator_core
// Set-1 scan code to US ASCII translator with modifier and lock tracking.
// ----------------------------------------------------------------------------
// Input channel: in_valid_i / in_stall_o with one raw scan code byte per
// request. Output channel: out_valid_o / out_stall_i with one result per
// request: a character (char_valid_o, char_code_o) and the lock LED bits
// (led_valid_o, led_bits_o), which always shows the current lock toggles.
// Each request is classified on entry and queued; the back end pops one
// request per cycle while the receiver does not stall, updates the
// modifier and lock state and loads the output register.
// Throughput: one request per cycle while the receiver does not stall,
// set by the single back-end lookup.
// Reset clears all modifier and lock state, empties the queue and drops
// any pending result.
// While the receiver stalls, the result holds and up to QueueDepth further
// requests are taken before in_stall_o rises.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_code_to_ascii_translator_core #(
  parameter int QueueDepth = 2
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] scan_code_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic            char_valid_o,
  output logic [6:0]      char_code_o,
  output logic            led_valid_o,
  output logic [2:0]      led_bits_o
);

  scta_pkg::req_t front_req;
  scta_pkg::req_t back_req;
  logic           q_full;
  logic           q_empty;
  logic           q_pop;

  scta_front u_front (
    .scan_code_i (scan_code_i),
    .req_o       (front_req)
  );

  scta_fifo #(
    .Depth (QueueDepth)
  ) u_fifo (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (in_valid_i),
    .push_req_i (front_req),
    .full_o     (q_full),
    .pop_i      (q_pop),
    .pop_req_o  (back_req),
    .empty_o    (q_empty)
  );

  scta_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (~q_empty),
    .req_i        (back_req),
    .req_pop_o    (q_pop),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .char_valid_o (char_valid_o),
    .char_code_o  (char_code_o),
    .led_valid_o  (led_valid_o),
    .led_bits_o   (led_bits_o)
  );

  assign in_stall_o = q_full;

endmodule

`default_nettype wire
